/* hdl/qrs_pkg.sv */
package qrs_pkg;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_LINEAR  = 3'd1,
        KIND_DOUBLE  = 3'd2,
        KIND_REAL    = 3'd3,
        KIND_COMPLEX = 3'd4
    } t_kind;

    // Classification that travels with an item from the front end to the back end.
    typedef struct packed {
        t_kind kind;
        logic  disc_ovf;
    } t_ctl;

    localparam int FIELD_W     = 32;
    localparam int DISC_OUT_W  = 64;
    localparam int FIFO_DEPTH  = 4;

endpackage

/* hdl/qrs_front.sv */
module qrs_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [W-1:0]  i_a,
    input  logic signed [W-1:0]  i_b,
    input  logic signed [W-1:0]  i_c,
    output logic                 o_valid,
    input  logic                 i_ready,
    output qrs_pkg::t_ctl        o_ctl,
    output logic [2*W-1:0]       o_disc,
    output logic [2*W:0]         o_dmag,
    output logic signed [W+F:0]  o_nb,
    output logic [W:0]           o_den,
    output logic                 o_den_neg
);
    import qrs_pkg::*;

    localparam logic signed [2*W+2:0] D_MAX = {4'b0000, {(2*W-1){1'b1}}};
    localparam logic signed [2*W+2:0] D_MIN = {4'b1111, {(2*W-1){1'b0}}};

    logic                   r_v1, r_v2;
    logic signed [W-1:0]    r_a, r_b, r_c;
    logic signed [2*W-1:0]  r_bb, r_ac;
    logic signed [2*W-1:0]  w_bb, w_ac;
    logic                   w_adv1, w_adv2;

    logic signed [2*W+2:0]  w_d, w_dabs;
    logic                   w_dneg, w_hi, w_lo, w_a_zero, w_b_zero;
    logic [2*W-1:0]         w_disc;
    logic signed [W+F:0]    w_nsrc;
    logic signed [W+1:0]    w_dsrc, w_dsabs;
    t_ctl                   n_ctl;

    assign w_adv2  = !r_v2 || i_ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v2;

    assign w_bb = i_b * i_b;
    assign w_ac = i_a * i_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_c  <= i_c;
            r_bb <= w_bb;
            r_ac <= w_ac;
        end
    end

    assign w_d      = (2*W+3)'(r_bb) - ((2*W+3)'(r_ac) <<< 2);
    assign w_dneg   = w_d[2*W+2];
    assign w_dabs   = w_dneg ? -w_d : w_d;
    assign w_hi     = w_d > D_MAX;
    assign w_lo     = w_d < D_MIN;
    assign w_a_zero = (r_a == '0);
    assign w_b_zero = (r_b == '0);
    assign w_disc   = w_hi ? D_MAX[2*W-1:0] : (w_lo ? D_MIN[2*W-1:0] : w_d[2*W-1:0]);

    // For a linear equation the divider sees -C/B, otherwise -B/(2A).
    assign w_nsrc = w_a_zero ? (W+F+1)'(r_c) : (W+F+1)'(r_b);
    assign w_dsrc = w_a_zero ? (W+2)'(r_b) : ((W+2)'(r_a) <<< 1);
    assign w_dsabs = w_dsrc[W+1] ? -w_dsrc : w_dsrc;

    always_comb begin
        n_ctl.disc_ovf = 1'b0;
        if (w_a_zero) begin
            n_ctl.kind = w_b_zero ? KIND_NONE : KIND_LINEAR;
        end else begin
            n_ctl.disc_ovf = w_hi || w_lo;
            if (w_dabs == '0) begin
                n_ctl.kind = KIND_DOUBLE;
            end else if (w_dneg) begin
                n_ctl.kind = KIND_COMPLEX;
            end else begin
                n_ctl.kind = KIND_REAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            o_ctl     <= n_ctl;
            o_disc    <= w_a_zero ? '0 : w_disc;
            o_dmag    <= w_a_zero ? '0 : w_dabs[2*W:0];
            o_nb      <= -(w_nsrc <<< F);
            o_den     <= w_dsabs[W:0];
            o_den_neg <= w_dsrc[W+1];
        end
    end

endmodule

/* hdl/qrs_fifo.sv */
module qrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (w_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

endmodule

/* hdl/qrs_sqrt.sv */
module qrs_sqrt #(
    parameter int RW = 98,
    parameter int TW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RW-1:0]     i_rad,
    input  logic [TW-1:0]     i_tag,
    output logic              o_valid,
    output logic [RW/2-1:0]   o_root,
    output logic [TW-1:0]     o_tag
);
    localparam int SW = RW / 2;

    logic            r_v    [0:SW];
    logic [RW-1:0]   r_rad  [0:SW];
    logic [SW+1:0]   r_rem  [0:SW];
    logic [SW-1:0]   r_root [0:SW];
    logic [TW-1:0]   r_tag  [0:SW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_tag[0]  <= i_tag;
        end
    end

    // One root bit per stage: bring down two radicand bits, try 4*root+1.
    for (genvar k = 1; k <= SW; k++) begin : g_step
        logic [SW+3:0] w_t, w_trial;
        logic          w_ge;

        assign w_t     = {r_rem[k-1], r_rad[k-1][RW-1:RW-2]};
        assign w_trial = (SW+4)'({r_root[k-1], 2'b01});
        assign w_ge    = w_t >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= r_rad[k-1] << 2;
                r_rem[k]  <= w_ge ? (SW+2)'(w_t - w_trial) : (SW+2)'(w_t);
                r_root[k] <= {r_root[k-1][SW-2:0], w_ge};
                r_tag[k]  <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_v[SW];
    assign o_root  = r_root[SW];
    assign o_tag   = r_tag[SW];

endmodule

/* hdl/qrs_div.sv */
module qrs_div #(
    parameter int NW = 50,
    parameter int DW = 33,
    parameter int QW = 33,
    parameter int TW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  logic [TW-1:0]  i_tag,
    output logic           o_valid,
    output logic [QW:0]    o_q,
    output logic           o_ovr,
    output logic [TW-1:0]  o_tag
);
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic            r_v    [0:QW];
    logic [DW-1:0]   r_rem  [0:QW];
    logic [DW-1:0]   r_den  [0:QW];
    logic [QW-1:0]   r_low  [0:QW];
    logic [QW-1:0]   r_q    [0:QW];
    logic            r_ovr  [0:QW];
    logic [TW-1:0]   r_tag  [0:QW];

    logic [HW-1:0]   w_hi;
    logic            w_ovr;
    logic [DW:0]     w_up;

    // A quotient of QW+1 bits or more saturates anyway, so only the low QW bits are formed.
    assign w_hi  = i_num[NW-1:QW];
    assign w_ovr = CW'(w_hi) >= CW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovr[0] <= w_ovr;
            r_rem[0] <= w_ovr ? '0 : DW'(w_hi);
            r_den[0] <= i_den;
            r_low[0] <= i_num[QW-1:0];
            r_q[0]   <= '0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] w_t, w_d;
        logic        w_ge;

        assign w_t  = {r_rem[k-1], r_low[k-1][QW-1]};
        assign w_d  = {1'b0, r_den[k-1]};
        assign w_ge = w_t >= w_d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? DW'(w_t - w_d) : DW'(w_t);
                r_den[k] <= r_den[k-1];
                r_low[k] <= r_low[k-1] << 1;
                r_q[k]   <= {r_q[k-1][QW-2:0], w_ge};
                r_ovr[k] <= r_ovr[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // Round half away from zero on the magnitude.
    assign w_up = {r_rem[QW], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q   <= (QW+1)'(r_q[QW]) + (QW+1)'(w_up >= {1'b0, r_den[QW]});
            o_ovr <= r_ovr[QW];
            o_tag <= r_tag[QW];
        end
    end

endmodule

/* hdl/qrs_back.sv */
module qrs_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  qrs_pkg::t_ctl        i_ctl,
    input  logic [2*W-1:0]       i_disc,
    input  logic [2*W:0]         i_dmag,
    input  logic signed [W+F:0]  i_nb,
    input  logic [W:0]           i_den,
    input  logic                 i_den_neg,
    output logic                 o_valid,
    input  logic                 i_ready,
    output qrs_pkg::t_kind       o_kind,
    output logic                 o_ovf,
    output logic [2*W-1:0]       o_disc,
    output logic signed [W-1:0]  o_fr,
    output logic signed [W-1:0]  o_fi,
    output logic signed [W-1:0]  o_sr,
    output logic signed [W-1:0]  o_si
);
    import qrs_pkg::*;

    localparam int RW = 2*W + 2 + 2*F;
    localparam int SW = RW / 2;
    localparam int NW = W + F + 2;
    localparam int QW = W + 1;
    localparam logic [W+1:0] LIM_P = {3'b000, {(W-1){1'b1}}};
    localparam logic [W+1:0] LIM_N = {3'b001, {(W-1){1'b0}}};

    typedef struct packed {
        t_ctl               ctl;
        logic [2*W-1:0]     disc;
        logic signed [W+F:0] nb;
        logic [W:0]         den;
        logic               den_neg;
    } t_sq_tag;

    typedef struct packed {
        t_ctl           ctl;
        logic [2*W-1:0] disc;
        logic           neg;
    } t_dv_tag;

    function automatic logic [W:0] sat_val(input logic [W+1:0] q, input logic ovr,
                                           input logic neg);
        logic [W+1:0] lim;
        logic [W+1:0] m;
        logic         ov;
        lim = neg ? LIM_N : LIM_P;
        ov  = ovr || (q > lim);
        m   = ov ? lim : q;
        if (neg) m = -m;
        return {ov, m[W-1:0]};
    endfunction

    logic                 w_en;
    t_sq_tag              w_sq_in, w_sq_out;
    logic                 w_sq_v;
    logic [SW-1:0]        w_root;

    logic signed [W+F+2:0] w_s, w_nbx, w_n0, w_n1, w_a0, w_a1;

    logic                 r_nv;
    t_ctl                 r_ctl;
    logic [2*W-1:0]       r_disc;
    logic [NW-1:0]        r_mag0, r_mag1;
    logic                 r_neg0, r_neg1;
    logic [W:0]           r_den;

    t_dv_tag              w_d0_in, w_d0_out;
    logic                 w_d0_v, w_d1_v, w_d0_ovr, w_d1_ovr, w_neg1;
    logic [QW:0]          w_q0, w_q1;

    logic [W:0]           w_v0, w_v1p, w_v1n;
    t_kind                n_kind;
    logic                 n_ovf;
    logic [W-1:0]         n_fr, n_fi, n_sr, n_si;
    logic                 r_out_v;

    assign w_en    = !r_out_v || i_ready;
    assign o_pop   = w_en;
    assign o_valid = r_out_v;

    assign w_sq_in = '{ctl: i_ctl, disc: i_disc, nb: i_nb, den: i_den, den_neg: i_den_neg};

    qrs_sqrt #(.RW(RW), .TW($bits(t_sq_tag))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_rad   ({1'b0, i_dmag, {(2*F){1'b0}}}),
        .i_tag   (w_sq_in),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_tag   (w_sq_out)
    );

    // Numerators: the root s only enters for two real roots and a complex pair.
    assign w_s   = $signed({2'b00, w_root});
    assign w_nbx = (W+F+3)'($signed(w_sq_out.nb));

    always_comb begin
        w_n0 = w_nbx;
        w_n1 = '0;
        case (w_sq_out.ctl.kind)
            KIND_REAL: begin
                w_n0 = w_nbx + w_s;
                w_n1 = w_nbx - w_s;
            end
            KIND_COMPLEX: w_n1 = w_s;
            default: ;
        endcase
    end

    assign w_a0 = w_n0[W+F+2] ? -w_n0 : w_n0;
    assign w_a1 = w_n1[W+F+2] ? -w_n1 : w_n1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else if (w_en) begin
            r_nv <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl  <= w_sq_out.ctl;
            r_disc <= w_sq_out.disc;
            r_mag0 <= w_a0[NW-1:0];
            r_mag1 <= w_a1[NW-1:0];
            r_neg0 <= w_n0[W+F+2] ^ w_sq_out.den_neg;
            r_neg1 <= w_n1[W+F+2] ^ w_sq_out.den_neg;
            r_den  <= w_sq_out.den;
        end
    end

    assign w_d0_in = '{ctl: r_ctl, disc: r_disc, neg: r_neg0};

    qrs_div #(.NW(NW), .DW(W+1), .QW(QW), .TW($bits(t_dv_tag))) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_nv),
        .i_num   (r_mag0),
        .i_den   (r_den),
        .i_tag   (w_d0_in),
        .o_valid (w_d0_v),
        .o_q     (w_q0),
        .o_ovr   (w_d0_ovr),
        .o_tag   (w_d0_out)
    );

    qrs_div #(.NW(NW), .DW(W+1), .QW(QW), .TW(1)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_nv),
        .i_num   (r_mag1),
        .i_den   (r_den),
        .i_tag   (r_neg1),
        .o_valid (w_d1_v),
        .o_q     (w_q1),
        .o_ovr   (w_d1_ovr),
        .o_tag   (w_neg1)
    );

    assign w_v0  = sat_val(w_q0, w_d0_ovr, w_d0_out.neg);
    assign w_v1p = sat_val(w_q1, w_d1_ovr, w_neg1);
    assign w_v1n = sat_val(w_q1, w_d1_ovr, !w_neg1);

    always_comb begin
        n_kind = w_d0_out.ctl.kind;
        n_ovf  = w_d0_out.ctl.disc_ovf;
        n_fr   = '0;
        n_fi   = '0;
        n_sr   = '0;
        n_si   = '0;
        unique case (w_d0_out.ctl.kind)
            KIND_LINEAR: begin
                n_fr  = w_v0[W-1:0];
                n_ovf = n_ovf | w_v0[W];
            end
            KIND_DOUBLE: begin
                n_fr  = w_v0[W-1:0];
                n_sr  = w_v0[W-1:0];
                n_ovf = n_ovf | w_v0[W];
            end
            KIND_REAL: begin
                n_fr  = w_v0[W-1:0];
                n_sr  = w_v1p[W-1:0];
                n_ovf = n_ovf | w_v0[W] | w_v1p[W];
            end
            KIND_COMPLEX: begin
                n_fr  = w_v0[W-1:0];
                n_sr  = w_v0[W-1:0];
                n_fi  = w_v1p[W-1:0];
                n_si  = w_v1n[W-1:0];
                n_ovf = n_ovf | w_v0[W] | w_v1p[W] | w_v1n[W];
            end
            default: n_ovf = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_d0_v && w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_kind <= n_kind;
            o_ovf  <= n_ovf;
            o_disc <= w_d0_out.disc;
            o_fr   <= n_fr;
            o_fi   <= n_fi;
            o_sr   <= n_sr;
            o_si   <= n_si;
        end
    end

endmodule

/* hdl/quadratic_root_solver_top.sv */
// Channel   Dir  Signals                          Content
// s_axis    in   tvalid, tready, tdata[95:0]      coefficients a, b, c
// m_axis    out  tvalid, tready, tdata[191:0],    discriminant and roots,
//                tuser[3:0]                       root kind and overflow
//
// One coefficient set is accepted per clock cycle while o_s_axis_tready is high. A result
// passes through the front end, the queue, the square root, the dividers and the output register;
// the depth is set by the square root and divider pipelines, one bit per stage.
// Reset only clears the valid flags and the queue pointers; there is no clearing pass.
// A stall on m_axis freezes the back end; the front end keeps accepting until its
// two stages and the four-entry queue between front and back are full.
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,   // coef_a, coef_b, coef_c
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [191:0] o_m_axis_tdata,   // discriminant, first_real, first_imag,
                                           // second_real, second_imag
    output logic [3:0]   o_m_axis_tuser    // root_kind, overflow
);
    import qrs_pkg::*;

    localparam int W = COEF_WIDTH;
    localparam int F = FRAC_BITS;

    typedef struct packed {
        t_ctl                ctl;
        logic [2*W-1:0]      disc;
        logic [2*W:0]        dmag;
        logic signed [W+F:0] nb;
        logic [W:0]          den;
        logic                den_neg;
    } t_item;

    t_item                w_fr_item, w_bk_item;
    logic                 w_fr_valid, w_q_ready, w_q_valid, w_pop;
    t_kind                w_kind;
    logic                 w_ovf;
    logic [2*W-1:0]       w_disc;
    logic signed [W-1:0]  w_fr, w_fi, w_sr, w_si;

    qrs_front #(.W(W), .F(F)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_a       (W'(i_s_axis_tdata[FIELD_W-1:0])),
        .i_b       (W'(i_s_axis_tdata[2*FIELD_W-1:FIELD_W])),
        .i_c       (W'(i_s_axis_tdata[3*FIELD_W-1:2*FIELD_W])),
        .o_valid   (w_fr_valid),
        .i_ready   (w_q_ready),
        .o_ctl     (w_fr_item.ctl),
        .o_disc    (w_fr_item.disc),
        .o_dmag    (w_fr_item.dmag),
        .o_nb      (w_fr_item.nb),
        .o_den     (w_fr_item.den),
        .o_den_neg (w_fr_item.den_neg)
    );

    qrs_fifo #(.WIDTH($bits(t_item)), .DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_valid),
        .o_ready (w_q_ready),
        .i_data  (w_fr_item),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_bk_item)
    );

    qrs_back #(.W(W), .F(F)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .o_pop     (w_pop),
        .i_ctl     (w_bk_item.ctl),
        .i_disc    (w_bk_item.disc),
        .i_dmag    (w_bk_item.dmag),
        .i_nb      (w_bk_item.nb),
        .i_den     (w_bk_item.den),
        .i_den_neg (w_bk_item.den_neg),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_kind    (w_kind),
        .o_ovf     (w_ovf),
        .o_disc    (w_disc),
        .o_fr      (w_fr),
        .o_fi      (w_fi),
        .o_sr      (w_sr),
        .o_si      (w_si)
    );

    assign o_m_axis_tdata = {FIELD_W'(w_si), FIELD_W'(w_sr), FIELD_W'(w_fi), FIELD_W'(w_fr),
                             DISC_OUT_W'($signed(w_disc))};
    assign o_m_axis_tuser = {w_ovf, w_kind};

endmodule
